>>> design/fopq_pkg.sv
// Package for the FIFO or priority queue: sizes, codes, transaction and control types.
package fopq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int PRIO_BITS    = 32;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                          opcode;
		logic [PAYLOAD_BITS-1:0]      payload;
		logic signed [PRIO_BITS-1:0]  priority_req;
	} in_item_t;

	typedef struct packed {
		logic                    result_valid;
		logic [PAYLOAD_BITS-1:0] head_payload;
		stat_t                   status;
		logic                    is_empty;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic find;
		logic scan_init;
		logic scan_step;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic empty;
		logic mode;
		logic multi;
		logic scan_last;
	} dp_stat_t;

endpackage

>>> design/fopq_ctrl.sv
// Controller state machine for the queue: sequences capture, search and commit.
module fopq_ctrl
	import fopq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				if (stat.op == OP_ADD) begin
					cmd.find = 1'b1;
				end else if ((stat.op == OP_REMOVE || stat.op == OP_PEEK) && !stat.empty) begin
					cmd.scan_init = 1'b1;
					// walk the entries only when priority order may pick a later slot
					if (stat.mode && stat.multi) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> design/fopq_dp.sv
// Datapath for the queue: entry registers, insert search, head scan and result register.
module fopq_dp
	import fopq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output out_item_t result,
	output logic      done
);

	logic [PAYLOAD_BITS-1:0]     pay_q  [QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0] prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]            count_q;
	logic                        mode_q;
	in_item_t                    item_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            pos_d;
	logic [IDX_W-1:0]            scan_idx_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [PAYLOAD_BITS-1:0]     best_pay_q;
	logic signed [PRIO_BITS-1:0] best_prio_q;
	out_item_t                   result_q;
	logic                        done_q;
	logic                        full;
	logic                        empty;
	logic                        do_add;
	logic                        do_remove;
	logic                        is_read;
	logic [CNT_W-1:0]            count_d;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign stat.op        = item_q.opcode;
	assign stat.empty     = empty;
	assign stat.mode      = mode_q;
	assign stat.multi     = (count_q > CNT_W'(1));
	assign stat.scan_last = ({1'b0, scan_idx_q} + CNT_W'(1)) == count_q;

	assign is_read   = (item_q.opcode == OP_REMOVE || item_q.opcode == OP_PEEK) && !empty;
	assign do_add    = cmd.commit && item_q.opcode == OP_ADD && !full;
	assign do_remove = cmd.commit && item_q.opcode == OP_REMOVE && !empty;

	// In priority mode insert before the first held entry of strictly lower priority, else at the tail
	always_comb begin
		pos_d = count_q;
		if (mode_q) begin
			for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
				if (CNT_W'(i) < count_q && item_q.priority_req > prio_q[IDX_W'(i)]) begin
					pos_d = CNT_W'(i);
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_add) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= cmd.commit;
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.find) begin
			pos_q <= pos_d;
		end
		if (cmd.scan_init) begin
			best_idx_q  <= '0;
			best_pay_q  <= pay_q[0];
			best_prio_q <= prio_q[0];
			scan_idx_q  <= IDX_W'(1);
		end
		if (cmd.scan_step) begin
			// keep the first of equal priorities: replace only on strictly greater
			if (prio_q[scan_idx_q] > best_prio_q) begin
				best_idx_q  <= scan_idx_q;
				best_pay_q  <= pay_q[scan_idx_q];
				best_prio_q <= prio_q[scan_idx_q];
			end
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (do_add) begin
				if (CNT_W'(i) == pos_q) begin
					pay_q[IDX_W'(i)]  <= item_q.payload;
					prio_q[IDX_W'(i)] <= item_q.priority_req;
				end else if (i > 0 && CNT_W'(i) > pos_q) begin
					pay_q[IDX_W'(i)]  <= pay_q[IDX_W'(i - 1)];
					prio_q[IDX_W'(i)] <= prio_q[IDX_W'(i - 1)];
				end
			end else if (do_remove) begin
				// close the gap behind the served entry
				if (i < QUEUE_DEPTH - 1 && IDX_W'(i) >= best_idx_q) begin
					pay_q[IDX_W'(i)]  <= pay_q[IDX_W'(i + 1)];
					prio_q[IDX_W'(i)] <= prio_q[IDX_W'(i + 1)];
				end
			end
		end
		if (cmd.commit) begin
			result_q.result_valid <= is_read;
			result_q.head_payload <= is_read ? best_pay_q : '0;
			result_q.is_empty     <= (count_d == '0);
			if (item_q.opcode == OP_ADD && full) begin
				result_q.status <= ST_FULL;
			end else if ((item_q.opcode == OP_REMOVE || item_q.opcode == OP_PEEK) && empty) begin
				result_q.status <= ST_EMPTY;
			end else begin
				result_q.status <= ST_OK;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

>>> design/fifo_or_priority_queue.sv
// Top level of the FIFO or priority queue: controller, datapath and configuration port.
//
// Bounded queue of up to 16 payload words with signed priorities. Issue a transaction
// with start while busy is low; busy rises on the next cycle and the result appears
// on result for exactly one cycle with done high. It must be taken then: the block
// does not wait. Busy falls in the same cycle done rises, so the next transaction
// can be issued while a result is shown. In priority mode a remove or peek of more
// than one held entry walks them one per cycle to find the first of greatest
// priority; adds and FIFO-mode reads do not walk the entries. queue_mode is written
// through cfg_valid/cfg_data (cfg_ready is always high) and should only change while
// the block is idle.
module fifo_or_priority_queue
	import fopq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fopq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fopq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.done     (done)
	);

endmodule

>>> design/fopq_checker.sv
// Port-level checker for the queue and its bind to the top level.
module fopq_checker
	import fopq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.result_valid |-> result.status == ST_OK)
		else $error("valid result with error status");

	a_zero_head: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.result_valid |-> result.head_payload == '0)
		else $error("head payload not zero on invalid result");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> !result.is_empty)
		else $error("dropped add reported an empty queue");

endmodule

bind fifo_or_priority_queue fopq_checker u_fopq_checker (.*);

>>> dv/tb_fifo_or_priority_queue.sv
// Testbench for fifo_or_priority_queue: directed and random commands checked against a shadow queue.
module tb_fifo_or_priority_queue;
	import fopq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1050;
	localparam int PHASES       = 8;
	localparam int TAIL_CYCLES  = 20;

	class queue_scoreboard;
		logic [PAYLOAD_BITS-1:0]     held_payload[QUEUE_DEPTH];
		logic signed [PRIO_BITS-1:0] held_prio[QUEUE_DEPTH];
		int                          held_count;
		bit                          queue_mode;
		out_item_t                   expected_results[$];
		int                          errors;
		int                          checked;
		int                          full_drops;
		int                          empty_reads;
		int                          served;

		function new();
			held_count  = 0;
			queue_mode  = 1'b0;
			errors      = 0;
			checked     = 0;
			full_drops  = 0;
			empty_reads = 0;
			served      = 0;
		endfunction

		// Apply one command to the shadow queue and return the result it should give.
		function out_item_t predict(in_item_t c);
			out_item_t r;
			int        pos;
			int        best;
			r = '0;
			r.status = ST_OK;
			case (c.opcode)
			OP_ADD: begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
					full_drops++;
				end else begin
					pos = held_count;
					// Insert ahead of the first strictly lower priority; ties keep arrival order.
					if (queue_mode) begin
						for (int i = 0; i < held_count; i++)
							if (pos == held_count && c.priority_req > held_prio[i])
								pos = i;
					end
					for (int i = held_count; i > pos; i--) begin
						held_payload[i] = held_payload[i-1];
						held_prio[i]    = held_prio[i-1];
					end
					held_payload[pos] = c.payload;
					held_prio[pos]    = c.priority_req;
					held_count++;
				end
			end
			OP_REMOVE, OP_PEEK: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
					empty_reads++;
				end else begin
					best = 0;
					// Serve the first entry of greatest priority; slots may be unsorted after a mode change.
					if (queue_mode) begin
						for (int i = 1; i < held_count; i++)
							if (held_prio[i] > held_prio[best])
								best = i;
					end
					r.result_valid = 1'b1;
					r.head_payload = held_payload[best];
					served++;
					if (c.opcode == OP_REMOVE) begin
						for (int i = best; i < held_count - 1; i++) begin
							held_payload[i] = held_payload[i+1];
							held_prio[i]    = held_prio[i+1];
						end
						held_count--;
					end
				end
			end
			default: ;
			endcase
			r.is_empty = (held_count == 0);
			return r;
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		function void note_command(in_item_t c);
			expected_results.push_back(predict(c));
		endfunction

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with none expected: valid %0b payload %h status %0d",
					got.result_valid, got.head_payload, got.status));
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (got.result_valid !== want.result_valid)
				report_mismatch($sformatf("result_valid %0b, want %0b",
					got.result_valid, want.result_valid));
			if (got.head_payload !== want.head_payload)
				report_mismatch($sformatf("head_payload %h, want %h",
					got.head_payload, want.head_payload));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.is_empty !== want.is_empty)
				report_mismatch($sformatf("is_empty %0b, want %0b", got.is_empty, want.is_empty));
		endtask
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      start     = 1'b0;
	logic      busy;
	in_item_t  item      = '0;
	logic      done;
	out_item_t result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;

	queue_scoreboard board;
	int              cycles      = 0;
	int              n_items     = 0;
	int              mode_writes = 0;
	bit              dense       = 1'b0;

	fifo_or_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_fifo_or_priority_queue: errors");
			$finish;
		end
	end

	function automatic in_item_t make_cmd(op_t op, logic [PAYLOAD_BITS-1:0] pay,
		logic signed [PRIO_BITS-1:0] pr);
		in_item_t c;
		c.opcode       = op;
		c.payload      = pay;
		c.priority_req = pr;
		return c;
	endfunction

	function automatic logic signed [PRIO_BITS-1:0] rand_priority();
		logic signed [PRIO_BITS-1:0] p;
		case ($urandom_range(0, 9))
		0: p = {1'b1, {(PRIO_BITS-1){1'b0}}};
		1: p = {1'b0, {(PRIO_BITS-1){1'b1}}};
		2, 3, 4, 5: begin
			// Narrow band to force ties
			p = $urandom_range(0, 8);
			p = p - 4;
		end
		default: p = $urandom;
		endcase
		return p;
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic int draw_gap();
		return dense ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic send(in_item_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= c;
		do @(posedge clk); while (busy);
		board.note_command(c);
		n_items++;
	endtask

	// Hold off new commands until every pending result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.expected_results.size() != 0 || busy);
	endtask

	task automatic set_mode(bit m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.queue_mode = m;
		mode_writes++;
	endtask

	initial begin
		logic signed [PRIO_BITS-1:0] p_min;
		logic signed [PRIO_BITS-1:0] p_max;
		in_item_t                    c;
		int                          phase_items;
		int                          burst_len;
		int                          kind;
		board = new();
		p_min = {1'b1, {(PRIO_BITS-1){1'b0}}};
		p_max = {1'b0, {(PRIO_BITS-1){1'b1}}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(1'b0);

		// FIFO order, empty reads, unused opcode, field extremes
		send(make_cmd(OP_REMOVE, '0, '0), draw_gap());
		send(make_cmd(OP_PEEK, '1, p_max), draw_gap());
		send(make_cmd(OP_NOP, '1, p_min), draw_gap());
		send(make_cmd(OP_ADD, '0, p_min), draw_gap());
		send(make_cmd(OP_ADD, 32'hA5A5_A5A5, '0), draw_gap());
		send(make_cmd(OP_ADD, '1, p_max), draw_gap());
		send(make_cmd(OP_ADD, 32'h5A5A_5A5A, p_max), draw_gap());
		send(make_cmd(OP_PEEK, '0, '0), draw_gap());
		send(make_cmd(OP_REMOVE, '0, '0), draw_gap());
		drain();

		// Switch to priority order with unsorted entries still held
		set_mode(1'b1);
		send(make_cmd(OP_PEEK, '0, '0), draw_gap());
		send(make_cmd(OP_ADD, 32'h0000_0001, -1), draw_gap());
		send(make_cmd(OP_ADD, 32'h0000_0002, p_max), draw_gap());
		send(make_cmd(OP_PEEK, '0, '0), draw_gap());
		for (int i = 0; i < 6; i++)
			send(make_cmd(OP_REMOVE, '0, '0), draw_gap());
		send(make_cmd(OP_ADD, 32'h0000_0003, p_min), draw_gap());
		send(make_cmd(OP_ADD, 32'h0000_0004, p_min), draw_gap());
		send(make_cmd(OP_REMOVE, '0, '0), draw_gap());
		send(make_cmd(OP_NOP, '0, '0), draw_gap());

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			dense = ($urandom_range(0, 2) == 0);
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / PHASES) begin
				kind      = $urandom_range(0, 99);
				burst_len = $urandom_range(1, 18);
				if (kind >= 96) begin
					drain();
					continue;
				end
				for (int k = 0; k < burst_len; k++) begin
					if (kind < 45)
						c = make_cmd(OP_ADD, rand_payload(), rand_priority());
					else if (kind < 85)
						c = make_cmd(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_REMOVE,
							rand_payload(), rand_priority());
					else
						c = make_cmd(op_t'($urandom_range(0, 3)), rand_payload(),
							rand_priority());
					send(c, draw_gap());
				end
				phase_items += burst_len;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.expected_results.size() != 0)
			board.report_mismatch($sformatf("%0d results never arrived",
				board.expected_results.size()));
		$display("run covered %0d commands, %0d results checked, %0d mode writes",
			n_items, board.checked, mode_writes);
		$display("adds dropped on full: %0d, reads of empty queue: %0d, entries served: %0d",
			board.full_drops, board.empty_reads, board.served);
		if (board.errors == 0)
			$display("tb_fifo_or_priority_queue: clean");
		else
			$display("tb_fifo_or_priority_queue: errors");
		$finish;
	end

endmodule
